>>> sv/crbb_pkg.sv
// Shared types and constants for the changed-region bounding box block.
`default_nettype none

package crbb_pkg;

    localparam int PIX_W      = 8;
    localparam int DIM_REG_W  = 13;
    localparam int THR_W      = 8;
    localparam int PAD_W      = 12;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int BOX_XY_W   = 12;
    localparam int BOX_WH_W   = 13;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 56;

    localparam int RST_FRAME_WIDTH  = 1920;
    localparam int RST_FRAME_HEIGHT = 1080;
    localparam int RST_THRESHOLD    = 10;
    localparam int RST_PADDING      = 0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_THRESHOLD    = 2'd2,
        REG_PADDING      = 2'd3
    } cfg_reg_t;

    // Per-stage load enables of the extent pipeline.
    typedef struct packed {
        logic clamp;
        logic span;
        logic sub;
        logic quot;
        logic fin;
    } ext_en_t;

endpackage

`default_nettype wire

>>> sv/changed_region_bounding_box_top.sv
// Changed-region bounding box: top level with pixel stage, frame tracking and result pipe.
// Throughput: one pixel pair per cycle; the input stalls only when the result pipe is full.
// Path: once a frame's last pixel is accepted, its result passes the box snapshot, four extent
//   stages and the output register behind the input register before it shows on m_tvalid.
// Non-final pixels produce no result; each frame's last pixel produces exactly one.
// Reset (aresetn low, synchronous): counters, box tracking, valids and config registers
//   return to their defaults; payload registers keep whatever they hold.
`default_nettype none

module changed_region_bounding_box_top #(
    parameter int GRID_STEP  = 4,
    parameter int ALIGN_STEP = 8,
    parameter int MAX_DIM    = 4096
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // config write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [crbb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [crbb_pkg::CFG_W-1:0]     cfg_wdata,

    // pixel pair requests
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // fields from bit 0: cur_blue, cur_green, cur_red, ref_blue, ref_green, ref_red
    input  wire logic [crbb_pkg::S_DATA_W-1:0]  s_tdata,

    // frame results
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // fields from bit 0: changed, box_x, box_y, box_width, box_height, zero fill
    output logic [crbb_pkg::M_DATA_W-1:0]       m_tdata
);
    import crbb_pkg::*;

    localparam int CW  = $clog2(MAX_DIM);      // coordinate width
    localparam int DW  = CW + 1;               // dimension width (holds MAX_DIM)
    localparam int PHW = (GRID_STEP > 1) ? $clog2(GRID_STEP) : 1;
    localparam int RST_W_EFF = (RST_FRAME_WIDTH > MAX_DIM) ? MAX_DIM : RST_FRAME_WIDTH;
    localparam int RST_H_EFF = (RST_FRAME_HEIGHT > MAX_DIM) ? MAX_DIM : RST_FRAME_HEIGHT;

    // ---------------- configuration ----------------
    logic [DIM_REG_W-1:0] frame_width_reg, frame_height_reg;
    logic [THR_W-1:0]     threshold_reg;
    logic [PAD_W-1:0]     padding_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= DIM_REG_W'(RST_FRAME_WIDTH);
            frame_height_reg <= DIM_REG_W'(RST_FRAME_HEIGHT);
            threshold_reg    <= THR_W'(RST_THRESHOLD);
            padding_reg      <= PAD_W'(RST_PADDING);
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[DIM_REG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[DIM_REG_W-1:0];
                REG_THRESHOLD:    threshold_reg    <= cfg_wdata[THR_W-1:0];
                REG_PADDING:      padding_reg      <= cfg_wdata[PAD_W-1:0];
                default: ;
            endcase
        end
    end

    // size 0 acts as 1, anything above MAX_DIM as MAX_DIM
    function automatic logic [DW-1:0] eff_dim(input logic [DIM_REG_W-1:0] v);
        logic [DW-1:0] r;
        if (v == '0)
            r = DW'(1);
        else if (32'(v) > 32'(MAX_DIM))
            r = DW'(MAX_DIM);
        else
            r = DW'(v);
        return r;
    endfunction

    logic [DW-1:0] w_eff, h_eff;
    assign w_eff = eff_dim(frame_width_reg);
    assign h_eff = eff_dim(frame_height_reg);

    // ---------------- pipeline control ----------------
    logic pix_v_reg, bx_v_reg, v1_reg, v2_reg, v3_reg, v4_reg, m_v_reg;
    logic out_free, e4_free, e3_free, e2_free, e1_free, bx_free, pix_free, pix_ship;
    logic frame_end;

    assign out_free = !m_v_reg  || m_tready;
    assign e4_free  = !v4_reg   || out_free;
    assign e3_free  = !v3_reg   || e4_free;
    assign e2_free  = !v2_reg   || e3_free;
    assign e1_free  = !v1_reg   || e2_free;
    assign bx_free  = !bx_v_reg || e1_free;
    // only a frame's last pixel needs room downstream
    assign pix_ship = pix_v_reg && (!frame_end || bx_free);
    assign pix_free = !pix_v_reg || pix_ship;
    assign s_tready = pix_free;

    // ---------------- input register ----------------
    logic [PIX_W-1:0] cur_b_reg, cur_g_reg, cur_r_reg, ref_b_reg, ref_g_reg, ref_r_reg;

    always_ff @(posedge aclk) begin
        if (pix_free) begin
            cur_b_reg <= s_tdata[7:0];
            cur_g_reg <= s_tdata[15:8];
            cur_r_reg <= s_tdata[23:16];
            ref_b_reg <= s_tdata[31:24];
            ref_g_reg <= s_tdata[39:32];
            ref_r_reg <= s_tdata[47:40];
        end
    end

    // ---------------- frame tracking ----------------
    logic [CW-1:0]  col_reg, row_reg, max_col_reg, max_row_reg;
    logic [DW-1:0]  min_col_reg, min_row_reg;
    logic [PHW-1:0] col_ph_reg, row_ph_reg;
    logic           any_reg;

    logic [PIX_W-1:0] d_b, d_g, d_r;
    logic           sample, hit, col_last, row_last, upd_any;
    logic [DW-1:0]  upd_min_col, upd_min_row;
    logic [CW-1:0]  upd_max_col, upd_max_row;
    logic [PHW-1:0] col_ph_step, row_ph_step;

    assign d_b = (cur_b_reg > ref_b_reg) ? cur_b_reg - ref_b_reg : ref_b_reg - cur_b_reg;
    assign d_g = (cur_g_reg > ref_g_reg) ? cur_g_reg - ref_g_reg : ref_g_reg - cur_g_reg;
    assign d_r = (cur_r_reg > ref_r_reg) ? cur_r_reg - ref_r_reg : ref_r_reg - cur_r_reg;

    // phase counters stand in for column/row modulo GRID_STEP
    assign sample = (col_ph_reg == '0) && (row_ph_reg == '0);
    assign hit    = sample && ((d_b > threshold_reg) || (d_g > threshold_reg)
                               || (d_r > threshold_reg));

    assign upd_min_col = (hit && (DW'(col_reg) < min_col_reg)) ? DW'(col_reg) : min_col_reg;
    assign upd_min_row = (hit && (DW'(row_reg) < min_row_reg)) ? DW'(row_reg) : min_row_reg;
    assign upd_max_col = (hit && (col_reg > max_col_reg)) ? col_reg : max_col_reg;
    assign upd_max_row = (hit && (row_reg > max_row_reg)) ? row_reg : max_row_reg;
    assign upd_any     = any_reg || hit;

    // compare in DW bits: a size shrunk mid-frame wraps the counter at the next pixel
    assign col_last  = (DW'(col_reg) + DW'(1)) >= w_eff;
    assign row_last  = (DW'(row_reg) + DW'(1)) >= h_eff;
    assign frame_end = col_last && row_last;

    assign col_ph_step = (col_ph_reg == PHW'(GRID_STEP - 1)) ? '0 : col_ph_reg + PHW'(1);
    assign row_ph_step = (row_ph_reg == PHW'(GRID_STEP - 1)) ? '0 : row_ph_reg + PHW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_v_reg   <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            col_ph_reg  <= '0;
            row_ph_reg  <= '0;
            min_col_reg <= DW'(RST_W_EFF);
            min_row_reg <= DW'(RST_H_EFF);
            max_col_reg <= '0;
            max_row_reg <= '0;
            any_reg     <= 1'b0;
        end else begin
            if (pix_free) begin
                pix_v_reg <= s_tvalid;
            end
            if (pix_ship) begin
                if (col_last) begin
                    col_reg    <= '0;
                    col_ph_reg <= '0;
                    if (row_last) begin
                        // frame done: box goes to the snapshot, tracking restarts
                        row_reg     <= '0;
                        row_ph_reg  <= '0;
                        min_col_reg <= w_eff;
                        min_row_reg <= h_eff;
                        max_col_reg <= '0;
                        max_row_reg <= '0;
                        any_reg     <= 1'b0;
                    end else begin
                        row_reg     <= row_reg + CW'(1);
                        row_ph_reg  <= row_ph_step;
                        min_col_reg <= upd_min_col;
                        min_row_reg <= upd_min_row;
                        max_col_reg <= upd_max_col;
                        max_row_reg <= upd_max_row;
                        any_reg     <= upd_any;
                    end
                end else begin
                    col_reg     <= col_reg + CW'(1);
                    col_ph_reg  <= col_ph_step;
                    min_col_reg <= upd_min_col;
                    min_row_reg <= upd_min_row;
                    max_col_reg <= upd_max_col;
                    max_row_reg <= upd_max_row;
                    any_reg     <= upd_any;
                end
            end
        end
    end

    // ---------------- box snapshot ----------------
    logic [DW-1:0] bx_lo_x_reg, bx_lo_y_reg, bx_dim_x_reg, bx_dim_y_reg;
    logic [CW-1:0] bx_hi_x_reg, bx_hi_y_reg;
    logic          bx_any_reg;

    always_ff @(posedge aclk) begin
        if (bx_free) begin
            bx_lo_x_reg  <= upd_min_col;
            bx_hi_x_reg  <= upd_max_col;
            bx_dim_x_reg <= w_eff;
            bx_lo_y_reg  <= upd_min_row;
            bx_hi_y_reg  <= upd_max_row;
            bx_dim_y_reg <= h_eff;
            bx_any_reg   <= upd_any;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bx_v_reg <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            m_v_reg  <= 1'b0;
        end else begin
            if (bx_free)  bx_v_reg <= pix_ship && frame_end;
            if (e1_free)  v1_reg   <= bx_v_reg;
            if (e2_free)  v2_reg   <= v1_reg;
            if (e3_free)  v3_reg   <= v2_reg;
            if (e4_free)  v4_reg   <= v3_reg;
            if (out_free) m_v_reg  <= v4_reg;
        end
    end

    // ---------------- extent pipes ----------------
    ext_en_t       ext_en;
    logic          keep_x, keep_y;
    logic [CW-1:0] start_x, start_y;
    logic [DW-1:0] len_x, len_y;

    assign ext_en.clamp = e1_free;
    assign ext_en.span  = e2_free;
    assign ext_en.sub   = e3_free;
    assign ext_en.quot  = e4_free;
    assign ext_en.fin   = out_free;

    crbb_extent #(
        .CW(CW), .DW(DW), .MAX_DIM(MAX_DIM), .ALIGN_STEP(ALIGN_STEP)
    ) u_ext_x (
        .aclk    (aclk),
        .en      (ext_en),
        .keep_in (bx_any_reg),
        .lo      (bx_lo_x_reg),
        .hi      (bx_hi_x_reg),
        .dim     (bx_dim_x_reg),
        .pad     (padding_reg),
        .keep_out(keep_x),
        .start   (start_x),
        .len     (len_x)
    );

    crbb_extent #(
        .CW(CW), .DW(DW), .MAX_DIM(MAX_DIM), .ALIGN_STEP(ALIGN_STEP)
    ) u_ext_y (
        .aclk    (aclk),
        .en      (ext_en),
        .keep_in (bx_any_reg),
        .lo      (bx_lo_y_reg),
        .hi      (bx_hi_y_reg),
        .dim     (bx_dim_y_reg),
        .pad     (padding_reg),
        .keep_out(keep_y),
        .start   (start_y),
        .len     (len_y)
    );

    // ---------------- result packing ----------------
    logic [31:0]         sx_w, sy_w, lx_w, ly_w;
    logic                changed;
    logic [BOX_XY_W-1:0] box_x, box_y;
    logic [BOX_WH_W-1:0] box_width, box_height;

    assign sx_w       = 32'(start_x);
    assign sy_w       = 32'(start_y);
    assign lx_w       = 32'(len_x);
    assign ly_w       = 32'(len_y);
    assign changed    = keep_x && keep_y;
    assign box_x      = sx_w[BOX_XY_W-1:0];
    assign box_y      = sy_w[BOX_XY_W-1:0];
    assign box_width  = lx_w[BOX_WH_W-1:0];
    assign box_height = ly_w[BOX_WH_W-1:0];

    assign m_tvalid = m_v_reg;
    assign m_tdata  = {5'b0, box_height, box_width, box_y, box_x, changed};

    // ---------------- checks ----------------
    a_nochange_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !changed) |-> (box_x == '0 && box_y == '0
                                    && box_width == '0 && box_height == '0))
        else $error("unchanged frame reported a nonzero box");

    a_changed_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && changed) |-> (box_width != '0 && box_height != '0))
        else $error("changed frame reported an empty box");

    a_track_order: assert property (@(posedge aclk) disable iff (!aresetn)
        any_reg |-> (min_col_reg <= DW'(max_col_reg) && min_row_reg <= DW'(max_row_reg)))
        else $error("tracked box min exceeds max");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (pix_v_reg && frame_end && bx_v_reg && !e1_free))
        else $error("input stalled without a full result pipe");

endmodule

`default_nettype wire

>>> sv/crbb_extent.sv
// One axis of the box: pad, clamp, align up and clamp again, over five stages.
`default_nettype none

module crbb_extent #(
    parameter int CW         = 12,
    parameter int DW         = 13,
    parameter int MAX_DIM    = 4096,
    parameter int ALIGN_STEP = 8
) (
    input  wire logic                     aclk,
    input  wire crbb_pkg::ext_en_t        en,
    input  wire logic                     keep_in,
    input  wire logic [DW-1:0]            lo,
    input  wire logic [CW-1:0]            hi,
    input  wire logic [DW-1:0]            dim,
    input  wire logic [crbb_pkg::PAD_W-1:0] pad,
    output logic                          keep_out,
    output logic [CW-1:0]                 start,
    output logic [DW-1:0]                 len
);
    import crbb_pkg::*;

    localparam int XW  = ((CW > PAD_W) ? CW : PAD_W) + 1;
    localparam int TW  = $clog2(MAX_DIM + ALIGN_STEP);
    localparam int AW  = $clog2(ALIGN_STEP);
    localparam int K   = TW + AW;
    localparam int PW  = TW + K + 1;
    localparam int GW  = TW + DW + 8;
    localparam logic [K:0] RECIP = (K+1)'(((64'd1 << K) + ALIGN_STEP - 1) / ALIGN_STEP);

    // clamp stage
    logic [CW-1:0] dm1;
    logic [CW-1:0] lo_c_next, hi_c_next;
    logic [CW-1:0] lo_c_reg, hi_c_reg, dm1_reg;
    logic [DW-1:0] dim1_reg;
    logic          keep1_reg;

    assign dm1       = CW'(dim - DW'(1));
    assign lo_c_next = (lo > DW'(dm1)) ? dm1 : lo[CW-1:0];
    assign hi_c_next = (hi > dm1) ? dm1 : hi;

    always_ff @(posedge aclk) begin
        if (en.clamp) begin
            lo_c_reg  <= lo_c_next;
            hi_c_reg  <= hi_c_next;
            dm1_reg   <= dm1;
            dim1_reg  <= dim;
            keep1_reg <= keep_in;
        end
    end

    // span stage: padded start and end
    logic [XW-1:0] lo_x, pad_x, e_raw;
    logic [CW-1:0] s_next, e_cap, e_next;
    logic [CW-1:0] s_reg, e_reg;
    logic [DW-1:0] dim2_reg;
    logic          keep2_reg;

    assign lo_x   = XW'(lo_c_reg);
    assign pad_x  = XW'(pad);
    assign s_next = (lo_x > pad_x) ? CW'(lo_x - pad_x) : '0;
    assign e_raw  = XW'(hi_c_reg) + pad_x;
    assign e_cap  = (e_raw > XW'(dm1_reg)) ? dm1_reg : e_raw[CW-1:0];
    assign e_next = (e_cap < s_next) ? s_next : e_cap;

    always_ff @(posedge aclk) begin
        if (en.span) begin
            s_reg     <= s_next;
            e_reg     <= e_next;
            dim2_reg  <= dim1_reg;
            keep2_reg <= keep1_reg;
        end
    end

    // sub stage: t = n + ALIGN_STEP - 1, room left to the frame edge
    logic [TW-1:0] t_reg;
    logic [DW-1:0] lim3_reg;
    logic [CW-1:0] s3_reg;
    logic          keep3_reg;

    always_ff @(posedge aclk) begin
        if (en.sub) begin
            t_reg     <= TW'(e_reg) - TW'(s_reg) + TW'(ALIGN_STEP);
            lim3_reg  <= dim2_reg - DW'(s_reg);
            s3_reg    <= s_reg;
            keep3_reg <= keep2_reg;
        end
    end

    // quot stage: t / ALIGN_STEP by reciprocal, exact for every t < 2^TW
    logic [PW-1:0] prod;
    logic [TW-1:0] q_reg;
    logic [DW-1:0] lim4_reg;
    logic [CW-1:0] s4_reg;
    logic          keep4_reg;

    assign prod = PW'(t_reg) * PW'(RECIP);

    always_ff @(posedge aclk) begin
        if (en.quot) begin
            q_reg     <= prod[K+TW-1:K];
            lim4_reg  <= lim3_reg;
            s4_reg    <= s3_reg;
            keep4_reg <= keep3_reg;
        end
    end

    // final stage: aligned length, clamped to the frame edge; zero when unchanged
    logic [GW-1:0] a_w;
    logic [DW-1:0] len_next;
    logic [CW-1:0] start_reg;
    logic [DW-1:0] len_reg;
    logic          keep_reg;

    assign a_w      = GW'(q_reg) * GW'(ALIGN_STEP);
    assign len_next = (a_w > GW'(lim4_reg)) ? lim4_reg : a_w[DW-1:0];

    always_ff @(posedge aclk) begin
        if (en.fin) begin
            start_reg <= keep4_reg ? s4_reg : '0;
            len_reg   <= keep4_reg ? len_next : '0;
            keep_reg  <= keep4_reg;
        end
    end

    assign keep_out = keep_reg;
    assign start    = start_reg;
    assign len      = len_reg;

endmodule

`default_nettype wire

>>> verif/crbb_box_checker.sv
// Frame box checker: watches both channels, predicts each frame's box, compares field by field.
module crbb_box_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [crbb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [crbb_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [crbb_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [crbb_pkg::M_DATA_W-1:0]  m_tdata,
    output int                             pending_boxes,
    output int                             mismatch_count,
    output int                             boxes_checked,
    output int                             pairs_seen
);
    import crbb_pkg::*;

    localparam int GRID_STEP  = 4;
    localparam int ALIGN_STEP = 8;
    localparam int MAX_DIM    = 4096;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic [BOX_WH_W-1:0] height;
        logic [BOX_WH_W-1:0] width;
        logic [BOX_XY_W-1:0] y;
        logic [BOX_XY_W-1:0] x;
        logic                changed;
    } frame_box_t;

    localparam int BOX_BITS = $bits(frame_box_t);

    frame_box_t           box_q[$];
    logic [DIM_REG_W-1:0] width_reg;
    logic [DIM_REG_W-1:0] height_reg;
    logic [THR_W-1:0]     thr_reg;
    logic [PAD_W-1:0]     pad_reg;
    int unsigned          col, row, min_col, min_row, max_col, max_row;
    bit                   any_chg;

    function automatic int unsigned eff_dim(logic [DIM_REG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic int unsigned chan_diff(logic [7:0] a, logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // pad, clamp, align up, clamp again to the frame edge
    function automatic void axis_extent(input int unsigned lo, input int unsigned hi,
                                        input int unsigned dim, input int unsigned pad,
                                        output int unsigned start, output int unsigned len);
        int unsigned s, e, n, a;
        if (lo > dim - 1) lo = dim - 1;
        if (hi > dim - 1) hi = dim - 1;
        s = (lo > pad) ? lo - pad : 0;
        e = hi + pad;
        if (e > dim - 1) e = dim - 1;
        if (e < s) e = s;
        n = e - s + 1;
        a = ((n + ALIGN_STEP - 1) / ALIGN_STEP) * ALIGN_STEP;
        if (a > dim - s) a = dim - s;
        start = s;
        len   = a;
    endfunction

    function void clear_box();
        min_col = eff_dim(width_reg);
        min_row = eff_dim(height_reg);
        max_col = 0;
        max_row = 0;
        any_chg = 0;
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : watch
        frame_box_t           got, want;
        int unsigned          w, h, bx, bw, by, bh;
        logic [S_DATA_W-1:0]  d;
        if (!aresetn) begin
            width_reg      = RST_FRAME_WIDTH;
            height_reg     = RST_FRAME_HEIGHT;
            thr_reg        = RST_THRESHOLD;
            pad_reg        = RST_PADDING;
            col            = 0;
            row            = 0;
            clear_box();
            box_q.delete();
            mismatch_count = 0;
            boxes_checked  = 0;
            pairs_seen     = 0;
            pending_boxes <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[BOX_BITS-1:0];
                boxes_checked++;
                if (box_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: frame result with none expected: expected nothing, got %h",
                             $time, m_tdata);
                end else begin
                    want = box_q.pop_front();
                    field_check("changed", want.changed, got.changed);
                    field_check("box_x", want.x, got.x);
                    field_check("box_y", want.y, got.y);
                    field_check("box_width", want.width, got.width);
                    field_check("box_height", want.height, got.height);
                end
                field_check("zero fill", 0, m_tdata[M_DATA_W-1:BOX_BITS]);
            end

            if (s_tvalid && s_tready) begin
                d = s_tdata;
                pairs_seen++;
                w = eff_dim(width_reg);
                h = eff_dim(height_reg);
                if (col % GRID_STEP == 0 && row % GRID_STEP == 0 &&
                    (chan_diff(d[7:0], d[31:24]) > thr_reg ||
                     chan_diff(d[15:8], d[39:32]) > thr_reg ||
                     chan_diff(d[23:16], d[47:40]) > thr_reg)) begin
                    any_chg = 1;
                    if (col < min_col) min_col = col;
                    if (row < min_row) min_row = row;
                    if (col > max_col) max_col = col;
                    if (row > max_row) max_row = row;
                end
                if (col + 1 >= w) begin
                    col = 0;
                    if (row + 1 >= h) begin
                        row  = 0;
                        want = '0;
                        if (any_chg) begin
                            axis_extent(min_col, max_col, w, pad_reg, bx, bw);
                            axis_extent(min_row, max_row, h, pad_reg, by, bh);
                            want.changed = 1'b1;
                            want.x       = BOX_XY_W'(bx);
                            want.y       = BOX_XY_W'(by);
                            want.width   = BOX_WH_W'(bw);
                            want.height  = BOX_WH_W'(bh);
                        end
                        box_q.push_back(want);
                        clear_box();
                    end else begin
                        row++;
                    end
                end else begin
                    col++;
                end
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  = cfg_wdata[DIM_REG_W-1:0];
                    REG_FRAME_HEIGHT: height_reg = cfg_wdata[DIM_REG_W-1:0];
                    REG_THRESHOLD:    thr_reg    = cfg_wdata[THR_W-1:0];
                    REG_PADDING:      pad_reg    = cfg_wdata[PAD_W-1:0];
                    default: ;
                endcase
            end

            pending_boxes <= box_q.size();
        end
    end

endmodule

>>> verif/changed_region_bounding_box_top_test.sv
// Testbench top: clock, reset, pixel pair stimulus, register writes and the verdict.
module changed_region_bounding_box_top_test;
    import crbb_pkg::*;

    // allowance for a frame result to come out after its last pixel; settle adds slack on top
    localparam int RESULT_LATENCY = 6;
    localparam int CYCLE_LIMIT    = 200_000;
    localparam int RANDOM_PAIRS   = 350;
    localparam int RANDOM_FRAMES  = 10;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wr_en = 1'b0;
    cfg_reg_t            cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0] s_tdata   = '0;   // cur_blue, cur_green, cur_red, ref_blue, ref_green, ref_red
    logic                s_tready;
    logic                m_tvalid;
    logic                m_tready  = 1'b1;
    logic [M_DATA_W-1:0] m_tdata;          // changed, box_x, box_y, box_width, box_height, zero fill

    int pending_boxes, mismatch_count, boxes_checked, pairs_seen;

    // idle shaping: percent chance per request (sender) or per cycle (receiver)
    int s_idle_pct  = 0;
    int m_idle_pct  = 0;
    int stall_left  = 0;
    bit calm        = 1'b0;

    int pairs_sent    = 0;
    int frames_sent   = 0;
    int settings_used = 0;
    int cycle_count   = 0;

    always #2 aclk = ~aclk;

    changed_region_bounding_box_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    crbb_box_checker box_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .pending_boxes  (pending_boxes),
        .mismatch_count (mismatch_count),
        .boxes_checked  (boxes_checked),
        .pairs_seen     (pairs_seen)
    );

    // Receiver back-pressure: m_tready drops in random bursts while not calm.
    always @(posedge aclk) begin
        if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            m_tready   <= 1'b1;
        end else if (!calm && $urandom_range(0, 99) < m_idle_pct) begin
            stall_left <= $urandom_range(1, 15);
            m_tready   <= 1'b0;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Cycle limit hit with %0d frame results still outstanding", pending_boxes);
            $display("FAILURE");
            $finish;
        end
    end

    // One register write; the caller drops cfg_wr_en after the last one.
    task automatic write_reg(cfg_reg_t idx, int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(value);
        @(posedge aclk);
    endtask

    task automatic apply_settings(int w, int h, int thr, int pad);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_PADDING, pad);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Offer one pixel pair request, maybe after an idle burst, and wait for acceptance.
    task automatic send_pair(logic [S_DATA_W-1:0] d);
        if (s_idle_pct != 0 && $urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        pairs_sent++;
    endtask

    // Drain: every expected frame result in, then let the pipeline run empty
    // (a partial frame leaves nothing expected but may still be in flight).
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_boxes != 0) @(posedge aclk);
        repeat (RESULT_LATENCY + 8) @(posedge aclk);
    endtask

    function automatic logic [S_DATA_W-1:0] pixel_pair(logic [7:0] cb, logic [7:0] cg,
                                                       logic [7:0] cr, logic [7:0] rb,
                                                       logic [7:0] rg, logic [7:0] rr);
        return {rr, rg, rb, cr, cg, cb};
    endfunction

    // {cur, ref} for one channel, exactly d apart, either one on top
    function automatic logic [15:0] channel_apart(int d);
        int lo;
        lo = $urandom_range(0, 255 - d);
        if ($urandom_range(0, 1)) return {8'(lo + d), 8'(lo)};
        return {8'(lo), 8'(lo + d)};
    endfunction

    // permille: chance that this pair is a clear change on one channel.
    // Otherwise every channel stays within the threshold (sometimes exactly at it);
    // in frames with changes a few pairs are plain noise.
    function automatic logic [S_DATA_W-1:0] make_pair(int thr, int permille);
        logic [15:0] ch [3];
        int          r, hit;
        r   = $urandom_range(0, 999);
        hit = -1;
        if (permille > 0 && r >= permille && r < permille + 50)
            return {16'($urandom), 32'($urandom)};
        if (r < permille && thr < 255) hit = int'($urandom_range(0, 2));
        for (int c = 0; c < 3; c++) begin
            if (c == hit) ch[c] = channel_apart($urandom_range(thr + 1, 255));
            else          ch[c] = channel_apart($urandom_range(0, thr));
        end
        return pixel_pair(ch[0][15:8], ch[1][15:8], ch[2][15:8],
                          ch[0][7:0], ch[1][7:0], ch[2][7:0]);
    endfunction

    // Whole frames; about one in five carries no change at all.
    task automatic send_frames(int w, int h, int thr, int n, int dens_hi);
        int wf, hf, dens;
        wf = (w == 0) ? 1 : (w > 4096 ? 4096 : w);
        hf = (h == 0) ? 1 : (h > 4096 ? 4096 : h);
        repeat (n) begin
            dens = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, dens_hi);
            repeat (wf * hf) send_pair(make_pair(thr, dens));
            frames_sent++;
        end
    endtask

    task automatic run_phase(int w, int h, int thr, int pad, int n, int dens_hi);
        settle();
        apply_settings(w, h, thr, pad);
        send_frames(w, h, thr, n, dens_hi);
    endtask

    // Small random frame sizes (0 stands in for 1), thresholds and padding at both ends.
    task automatic random_phase(int n);
        int w, h, thr, pad;
        case ($urandom_range(0, 9))
            0:       w = 0;
            1:       w = 1;
            default: w = $urandom_range(2, 16);
        endcase
        case ($urandom_range(0, 9))
            0:       h = 0;
            1:       h = 1;
            default: h = $urandom_range(2, 9);
        endcase
        case ($urandom_range(0, 7))
            0:       thr = 0;
            1:       thr = 255;
            2:       thr = $urandom_range(0, 255);
            default: thr = $urandom_range(1, 40);
        endcase
        case ($urandom_range(0, 7))
            0:       pad = 4095;
            1:       pad = $urandom_range(0, 4095);
            2, 3:    pad = 0;
            default: pad = $urandom_range(1, 6);
        endcase
        if (!calm) begin
            case ($urandom_range(0, 3))
                0:       s_idle_pct = 0;
                1:       s_idle_pct = 5;
                2:       s_idle_pct = 20;
                default: s_idle_pct = 50;
            endcase
            case ($urandom_range(0, 3))
                0:       m_idle_pct <= 0;
                1:       m_idle_pct <= 5;
                2:       m_idle_pct <= 20;
                default: m_idle_pct <= 50;
            endcase
        end
        run_phase(w, h, thr, pad, n, 400);
    endtask

    initial begin : stimulus
        int rand_pairs_base, rand_frames_base;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: 0x0 acts as a 1x1 frame, so every request closes a frame.
        // Threshold 10: at the threshold no change, one above it a change on
        // each channel (on red in both directions), and full-scale swings.
        apply_settings(0, 0, 10, 0);
        send_pair(pixel_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_pair(pixel_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        send_pair(pixel_pair(8'd20, 8'd7, 8'd99, 8'd10, 8'd7, 8'd99));
        send_pair(pixel_pair(8'd3, 8'd245, 8'd120, 8'd3, 8'd255, 8'd110));
        send_pair(pixel_pair(8'd0, 8'd50, 8'd50, 8'd11, 8'd50, 8'd50));
        send_pair(pixel_pair(8'd50, 8'd11, 8'd50, 8'd50, 8'd0, 8'd50));
        send_pair(pixel_pair(8'd60, 8'd60, 8'd200, 8'd60, 8'd60, 8'd189));
        send_pair(pixel_pair(8'd60, 8'd60, 8'd189, 8'd60, 8'd60, 8'd200));
        send_pair(pixel_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
        send_pair(pixel_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
        // threshold 0: any difference counts; full padding clamps to the 1x1 frame
        settle();
        apply_settings(1, 1, 0, 4095);
        send_pair(pixel_pair(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128));
        send_pair(pixel_pair(8'd40, 8'd40, 8'd41, 8'd40, 8'd40, 8'd40));
        send_pair(pixel_pair(8'd254, 8'd9, 8'd9, 8'd255, 8'd9, 8'd9));
        // threshold 255: nothing can exceed it
        settle();
        apply_settings(1, 1, 255, 7);
        send_pair(pixel_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
        send_pair(pixel_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));

        // Random small frames until enough pixels and frame results have gone by.
        rand_pairs_base  = pairs_sent;
        rand_frames_base = frames_sent;
        while (pairs_sent - rand_pairs_base < RANDOM_PAIRS ||
               frames_sent - rand_frames_base < RANDOM_FRAMES)
            random_phase($urandom_range(1, 4));

        // Oversize sizes act as 4096: a long partial row (then a long partial column),
        // closed by a shrink that wraps the counter and clamps the recorded box.
        settle();
        apply_settings(8191, 1, 20, 3);
        repeat (80) send_pair(make_pair(20, 150));
        settle();
        apply_settings(16, 1, 20, 3);
        send_pair(make_pair(20, 150));
        frames_sent++;
        settle();
        apply_settings(1, 8191, 20, 2);
        repeat (80) send_pair(make_pair(20, 150));
        settle();
        apply_settings(1, 16, 20, 2);
        send_pair(make_pair(20, 150));
        frames_sent++;

        // Shrink mid-frame: counters past the new size wrap on the next request and
        // coordinates recorded beyond it get clamped into the box.
        settle();
        apply_settings(16, 16, 10, 1);
        repeat (70) send_pair(make_pair(10, 600));
        settle();
        apply_settings(4, 4, 10, 1);
        send_pair(make_pair(10, 600));
        frames_sent++;
        send_frames(4, 4, 10, 2, 300);

        // Tail with both sides streaming flat out.
        calm        = 1'b1;
        s_idle_pct  = 0;
        m_idle_pct <= 0;
        random_phase(2);
        settle();

        $display("Checked %0d frame results from %0d pixel pair requests over %0d register settings",
                 boxes_checked, pairs_seen, settings_used);
        $display("Frames from 1x1 to 16x9 plus oversize and shrunk sizes, thresholds 0 to 255, padding 0 to 4095");
        if (mismatch_count == 0 && pending_boxes == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
